/* hw/rtl/plaid_band_overlay_defines.svh */
// Assertion shorthands used by the checker of the overlay block.
`ifndef PLAID_BAND_OVERLAY_DEFINES_SVH
`define PLAID_BAND_OVERLAY_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define PBO_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define PBO_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/pbo_pkg.sv */
package pbo_pkg;

	localparam int COORD_BITS = 12;
	localparam int CHAN_W     = 8;
	localparam int BAND_W     = 8;
	localparam int WPH_W      = 9;
	localparam int FPH_W      = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = COORD_BITS;

	localparam int Q_DEPTH   = 2;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDE_BAND    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FINE_BAND    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_BAND  = 3'd4;

	localparam logic [COORD_BITS-1:0] RST_FRAME_WIDTH  = COORD_BITS'(640);
	localparam logic [COORD_BITS-1:0] RST_FRAME_HEIGHT = COORD_BITS'(480);
	localparam logic [BAND_W-1:0]     RST_WIDE_BAND    = 8'd45;
	localparam logic [BAND_W-1:0]     RST_FINE_BAND    = 8'd9;
	localparam logic [BAND_W-1:0]     RST_MEDIUM_BAND  = 8'd15;

	typedef struct packed {
		logic [CHAN_W-1:0] blue_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] red_in;
		logic              start_of_frame;
	} pix_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] red_out;
		logic              end_of_frame;
	} pix_out_t;

	typedef struct packed {
		logic h_wide;
		logic v_wide;
		logic h_fine;
		logic v_fine;
		logic h_med;
		logic v_med;
	} bands_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
		bands_t            bands;
		logic              eof;
	} mid_t;

endpackage

/* hw/rtl/pbo_front.sv */
module pbo_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  pbo_pkg::pix_in_t                 pix_in,
	input  logic                             cfg_we,
	input  logic [pbo_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [pbo_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                             mid_wr,
	output pbo_pkg::mid_t                    mid_item,
	input  logic                             mid_full
);

	localparam int CB = pbo_pkg::COORD_BITS;
	localparam int WW = pbo_pkg::WPH_W;
	localparam int FW = pbo_pkg::FPH_W;
	localparam int BW = pbo_pkg::BAND_W;

	logic [CB-1:0] frame_width_q, frame_height_q;
	logic [BW-1:0] wide_band_q, fine_band_q, medium_band_q;

	logic [CB-1:0] column_q, row_q;
	logic [WW-1:0] col_wph_q, row_wph_q;
	logic [FW-1:0] col_fph_q, row_fph_q;

	logic [CB-1:0] col, row;
	logic [WW-1:0] cwp, rwp;
	logic [FW-1:0] cfp, rfp;

	logic [BW-1:0] w, s, m;
	logic [WW-1:0] p2;
	logic [FW-1:0] p4, fs, ms;
	logic signed [CB+1:0] v_lhs, v_rhs;
	logic          last_col, last_row, accept;
	logic [WW:0]   cwp_inc, rwp_inc;
	logic [FW:0]   cfp_inc, rfp_inc;
	pbo_pkg::bands_t bands;

	function automatic logic in_band(input logic [FW-1:0] p, input logic [FW-1:0] start,
			input logic [FW-1:0] period, input logic [BW-1:0] len);
		logic [FW:0] off;
		if (p >= start) begin
			off = {1'b0, p} - {1'b0, start};
		end else begin
			off = {1'b0, p} + {1'b0, period} - {1'b0, start};
		end
		return off < (FW + 1)'(len);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= pbo_pkg::RST_FRAME_WIDTH;
			frame_height_q <= pbo_pkg::RST_FRAME_HEIGHT;
			wide_band_q    <= pbo_pkg::RST_WIDE_BAND;
			fine_band_q    <= pbo_pkg::RST_FINE_BAND;
			medium_band_q  <= pbo_pkg::RST_MEDIUM_BAND;
		end else if (cfg_we) begin
			case (cfg_idx)
				pbo_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[CB-1:0];
				pbo_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[CB-1:0];
				pbo_pkg::REG_WIDE_BAND:    wide_band_q    <= cfg_data[BW-1:0];
				pbo_pkg::REG_FINE_BAND:    fine_band_q    <= cfg_data[BW-1:0];
				pbo_pkg::REG_MEDIUM_BAND:  medium_band_q  <= cfg_data[BW-1:0];
				default: ;
			endcase
		end
	end

	// Band geometry; a zero wide band counts as one.
	always_comb begin
		w  = (wide_band_q == '0) ? BW'(1) : wide_band_q;
		s  = (fine_band_q < w) ? fine_band_q : w;
		m  = (medium_band_q < w) ? medium_band_q : w;
		p2 = {w, 1'b0};
		p4 = {w, 2'b00};
		fs = FW'(w) + FW'((w - s) >> 1);
		ms = FW'({w, 1'b0}) + FW'(w) + FW'((w - m) >> 1);
	end

	// Start of frame puts this pixel at the origin.
	always_comb begin
		col = pix_in.start_of_frame ? '0 : column_q;
		row = pix_in.start_of_frame ? '0 : row_q;
		cwp = pix_in.start_of_frame ? '0 : col_wph_q;
		rwp = pix_in.start_of_frame ? '0 : row_wph_q;
		cfp = pix_in.start_of_frame ? '0 : col_fph_q;
		rfp = pix_in.start_of_frame ? '0 : row_fph_q;
	end

	always_comb begin
		// Vertical wide band only where its whole width fits in the line.
		v_lhs = $signed((CB + 2)'(col)) - $signed((CB + 2)'(cwp)) + $signed((CB + 2)'(p2));
		v_rhs = $signed((CB + 2)'(frame_width_q));
		bands.h_wide = rwp >= WW'(w);
		bands.v_wide = (cwp >= WW'(w)) && (v_lhs < v_rhs);
		bands.h_fine = in_band(rfp, fs, p4, s);
		bands.v_fine = in_band(cfp, fs, p4, s);
		bands.h_med  = in_band(rfp, ms, p4, m);
		bands.v_med  = in_band(cfp, ms, p4, m);
	end

	always_comb begin
		last_col = ({1'b0, col} + 1'b1) >= {1'b0, frame_width_q};
		last_row = ({1'b0, row} + 1'b1) >= {1'b0, frame_height_q};
		cwp_inc  = {1'b0, cwp} + 1'b1;
		rwp_inc  = {1'b0, rwp} + 1'b1;
		cfp_inc  = {1'b0, cfp} + 1'b1;
		rfp_inc  = {1'b0, rfp} + 1'b1;
	end

	assign accept = push && !mid_full;
	assign full   = mid_full;
	assign mid_wr = accept;

	always_comb begin
		mid_item.blue  = pix_in.blue_in;
		mid_item.green = pix_in.green_in;
		mid_item.red   = pix_in.red_in;
		mid_item.bands = bands;
		mid_item.eof   = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q  <= '0;
			row_q     <= '0;
			col_wph_q <= '0;
			row_wph_q <= '0;
			col_fph_q <= '0;
			row_fph_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				column_q  <= '0;
				col_wph_q <= '0;
				col_fph_q <= '0;
				if (last_row) begin
					row_q     <= '0;
					row_wph_q <= '0;
					row_fph_q <= '0;
				end else begin
					row_q     <= row + 1'b1;
					row_wph_q <= (rwp_inc >= {1'b0, p2}) ? '0 : rwp_inc[WW-1:0];
					row_fph_q <= (rfp_inc >= {1'b0, p4}) ? '0 : rfp_inc[FW-1:0];
				end
			end else begin
				column_q  <= col + 1'b1;
				col_wph_q <= (cwp_inc >= {1'b0, p2}) ? '0 : cwp_inc[WW-1:0];
				col_fph_q <= (cfp_inc >= {1'b0, p4}) ? '0 : cfp_inc[FW-1:0];
				row_q     <= row;
				row_wph_q <= rwp;
				row_fph_q <= rfp;
			end
		end
	end

endmodule

/* hw/rtl/pbo_queue.sv */
module pbo_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  pbo_pkg::mid_t wr_item,
	output logic          full,
	input  logic          rd_en,
	output pbo_pkg::mid_t rd_item,
	output logic          empty
);

	pbo_pkg::mid_t                  mem_q [pbo_pkg::Q_DEPTH];
	logic [pbo_pkg::Q_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [pbo_pkg::Q_CNT_W-1:0]    count_q;
	logic                           do_wr, do_rd;

	assign full    = count_q == pbo_pkg::Q_CNT_W'(pbo_pkg::Q_DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	// Pointers wrap naturally: the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

/* hw/rtl/pbo_back.sv */
module pbo_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pbo_pkg::mid_t     mid_item,
	input  logic              mid_empty,
	output logic              mid_rd,
	output pbo_pkg::pix_out_t pix_out,
	output logic              empty,
	input  logic              pop
);

	localparam int CW = pbo_pkg::CHAN_W;

	localparam logic [CW-1:0] WIDE_B = 8'd200;
	localparam logic [CW-1:0] WIDE_G = 8'd0;
	localparam logic [CW-1:0] WIDE_R = 8'd0;
	localparam logic [CW-1:0] FINE_K = 8'd255;
	localparam logic [CW-1:0] MED_B  = 8'd100;
	localparam logic [CW-1:0] MED_G  = 8'd200;
	localparam logic [CW-1:0] MED_R  = 8'd0;

	pbo_pkg::pix_out_t             buf_q [pbo_pkg::Q_DEPTH];
	logic [pbo_pkg::Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [pbo_pkg::Q_CNT_W-1:0]   count_q;
	logic                          out_full, do_wr, do_rd;
	pbo_pkg::pix_out_t             res;

	function automatic logic [CW-1:0] blend(input logic [CW-1:0] c, input logic [CW-1:0] k);
		logic [CW:0] sum;
		sum = {1'b0, c} + {1'b0, k};
		return sum[CW:1];
	endfunction

	// Apply the six blends in fixed order.
	always_comb begin
		logic [CW-1:0] b, g, r;
		b = mid_item.blue;
		g = mid_item.green;
		r = mid_item.red;
		if (mid_item.bands.h_wide) begin
			b = blend(b, WIDE_B); g = blend(g, WIDE_G); r = blend(r, WIDE_R);
		end
		if (mid_item.bands.v_wide) begin
			b = blend(b, WIDE_B); g = blend(g, WIDE_G); r = blend(r, WIDE_R);
		end
		if (mid_item.bands.h_fine) begin
			b = blend(b, FINE_K); g = blend(g, FINE_K); r = blend(r, FINE_K);
		end
		if (mid_item.bands.v_fine) begin
			b = blend(b, FINE_K); g = blend(g, FINE_K); r = blend(r, FINE_K);
		end
		if (mid_item.bands.h_med) begin
			b = blend(b, MED_B); g = blend(g, MED_G); r = blend(r, MED_R);
		end
		if (mid_item.bands.v_med) begin
			b = blend(b, MED_B); g = blend(g, MED_G); r = blend(r, MED_R);
		end
		res.blue_out     = b;
		res.green_out    = g;
		res.red_out      = r;
		res.end_of_frame = mid_item.eof;
	end

	assign out_full = count_q == pbo_pkg::Q_CNT_W'(pbo_pkg::Q_DEPTH);
	assign empty    = count_q == '0;
	assign do_wr    = !mid_empty && !out_full;
	assign do_rd    = pop && !empty;
	assign mid_rd   = do_wr;
	assign pix_out  = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) buf_q[wr_ptr_q] <= res;
	end

endmodule

/* hw/rtl/plaid_band_overlay.sv */
// Plaid overlay for a raster stream of BGR pixels: one pixel beat in gives one
// pixel beat out, blended with up to six stripes, of three colours, from its row
// and column, with end_of_frame raised on the last pixel of the frame. The block
// takes one pixel per clock as long as the result side keeps popping; a pushed
// pixel is written into the queue after the classifier when it is accepted, then
// into the queue after the blend stage, and can be popped from there. The front
// end's position counters advance once per accepted pixel, and two-entry queues
// after the classifier and after the blend stage absorb a stall on either side.
// Write the geometry registers only while no pixel is in flight.
module plaid_band_overlay (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  pbo_pkg::pix_in_t                 pix_in,
	input  logic                             pop,
	output logic                             empty,
	output pbo_pkg::pix_out_t                pix_out,
	input  logic                             cfg_we,
	input  logic [pbo_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [pbo_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic          mid_wr, mid_full, mid_rd, mid_empty;
	pbo_pkg::mid_t mid_wr_item, mid_rd_item;

	pbo_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.pix_in   (pix_in),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.mid_wr   (mid_wr),
		.mid_item (mid_wr_item),
		.mid_full (mid_full)
	);

	pbo_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr),
		.wr_item (mid_wr_item),
		.full    (mid_full),
		.rd_en   (mid_rd),
		.rd_item (mid_rd_item),
		.empty   (mid_empty)
	);

	pbo_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_item  (mid_rd_item),
		.mid_empty (mid_empty),
		.mid_rd    (mid_rd),
		.pix_out   (pix_out),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

/* hw/rtl/pbo_checker.sv */
`include "plaid_band_overlay_defines.svh"

module pbo_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input logic              full,
	input logic              pop,
	input logic              empty,
	input pbo_pkg::pix_out_t pix_out
);

	// The input side only backs up once the result side is holding beats.
	`PBO_ASSERT_IMP(a_full_needs_results, full, !empty, "input full with no result waiting")

	// An accepted pixel passes the middle queue and the blend stage to the result side.
	`PBO_ASSERT_IMP(a_accept_latency, push && !full, ##2 !empty, "accepted pixel did not emerge")

	// A waiting result holds until popped.
	`PBO_ASSERT_NXT(a_result_holds, !empty && !pop, !empty && $stable(pix_out),
		"waiting result changed")

endmodule

bind plaid_band_overlay pbo_checker u_checker (.*);

/* verif/tb.sv */
module tb;
	import pbo_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int MAX_IDLE     = 17;
	localparam int SETTLE       = 4;
	localparam int RANDOM_ITEMS = 1400;

	localparam logic [23:0] NAVY  = {8'd200, 8'd0, 8'd0};
	localparam logic [23:0] WHITE = {8'd255, 8'd255, 8'd255};
	localparam logic [23:0] TEAL  = {8'd100, 8'd200, 8'd0};

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  push     = 1'b0;
	logic                  full;
	pix_in_t               pix_in   = '0;
	logic                  pop      = 1'b0;
	logic                  empty;
	pix_out_t              pix_out;
	logic                  cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	plaid_band_overlay dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.pix_in   (pix_in),
		.pop      (pop),
		.empty    (empty),
		.pix_out  (pix_out),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Geometry as last written, and the raster position of the next pixel
	logic [COORD_BITS-1:0] width_reg  = RST_FRAME_WIDTH;
	logic [COORD_BITS-1:0] height_reg = RST_FRAME_HEIGHT;
	logic [BAND_W-1:0]     wide_reg   = RST_WIDE_BAND;
	logic [BAND_W-1:0]     fine_reg   = RST_FINE_BAND;
	logic [BAND_W-1:0]     med_reg    = RST_MEDIUM_BAND;
	logic [COORD_BITS-1:0] col        = '0;
	logic [COORD_BITS-1:0] row        = '0;
	logic [WPH_W-1:0]      col_wide   = '0;
	logic [WPH_W-1:0]      row_wide   = '0;
	logic [FPH_W-1:0]      col_fine   = '0;
	logic [FPH_W-1:0]      row_fine   = '0;

	pix_out_t expected_pixels[$];
	int       pixels_sent   = 0;
	int       pixels_popped = 0;
	int       mismatches    = 0;
	int       cycles        = 0;
	bit       feed_steady   = 1'b0;
	bit       drain_steady  = 1'b0;

	always #4 clk = ~clk;

	function automatic int unsigned band_offset(int unsigned p, int unsigned start,
			int unsigned period);
		return (p >= start) ? (p - start) : (p + period - start);
	endfunction

	function automatic int unsigned step_phase(int unsigned p, int unsigned period);
		return (p + 1 >= period) ? 0 : (p + 1);
	endfunction

	function automatic logic [23:0] average(logic [23:0] c, logic [23:0] k);
		logic [23:0] m;
		for (int i = 0; i < 3; i++)
			m[i*8 +: 8] = 8'((9'(c[i*8 +: 8]) + 9'(k[i*8 +: 8])) >> 1);
		return m;
	endfunction

	function automatic pix_out_t overlay_pixel(pix_in_t px);
		int unsigned w, s, m, fs, ms;
		bands_t      hit;
		logic [23:0] bgr;
		bit          last_col, last_row;
		pix_out_t    res;
		if (px.start_of_frame) begin
			col = '0;
			row = '0;
			col_wide = '0;
			row_wide = '0;
			col_fine = '0;
			row_fine = '0;
		end
		w = (wide_reg == 0) ? 1 : wide_reg;
		s = (fine_reg < w) ? fine_reg : w;
		m = (med_reg < w) ? med_reg : w;
		fs = w + ((w - s) >> 1);
		ms = 3 * w + ((w - m) >> 1);
		hit.h_wide = row_wide >= w;
		// a vertical wide band is dropped when it would run past the right edge
		hit.v_wide = col_wide >= w &&
			int'(col) - int'(col_wide) + 2 * int'(w) < int'(width_reg);
		hit.h_fine = band_offset(row_fine, fs, 4 * w) < s;
		hit.v_fine = band_offset(col_fine, fs, 4 * w) < s;
		hit.h_med  = band_offset(row_fine, ms, 4 * w) < m;
		hit.v_med  = band_offset(col_fine, ms, 4 * w) < m;
		bgr = {px.blue_in, px.green_in, px.red_in};
		if (hit.h_wide) bgr = average(bgr, NAVY);
		if (hit.v_wide) bgr = average(bgr, NAVY);
		if (hit.h_fine) bgr = average(bgr, WHITE);
		if (hit.v_fine) bgr = average(bgr, WHITE);
		if (hit.h_med)  bgr = average(bgr, TEAL);
		if (hit.v_med)  bgr = average(bgr, TEAL);
		last_col = col + 32'd1 >= width_reg;
		last_row = row + 32'd1 >= height_reg;
		res.blue_out     = bgr[23:16];
		res.green_out    = bgr[15:8];
		res.red_out      = bgr[7:0];
		res.end_of_frame = last_col && last_row;
		if (last_col) begin
			col = '0;
			col_wide = '0;
			col_fine = '0;
			if (last_row) begin
				row = '0;
				row_wide = '0;
				row_fine = '0;
			end else begin
				row = row + 1'b1;
				row_wide = WPH_W'(step_phase(row_wide, 2 * w));
				row_fine = FPH_W'(step_phase(row_fine, 4 * w));
			end
		end else begin
			col = col + 1'b1;
			col_wide = WPH_W'(step_phase(col_wide, 2 * w));
			col_fine = FPH_W'(step_phase(col_fine, 4 * w));
		end
		return res;
	endfunction

	function automatic int idle_cycles(bit steady);
		return steady ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	function automatic pix_in_t make_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
			bit sof);
		pix_in_t px;
		px.blue_in = b;
		px.green_in = g;
		px.red_in = r;
		px.start_of_frame = sof;
		return px;
	endfunction

	function automatic pix_in_t random_pixel(bit sof);
		return make_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), sof);
	endfunction

	task automatic send_pixel(input pix_in_t px);
		int gap;
		gap = idle_cycles(feed_steady);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		pix_in <= px;
		do @(posedge clk); while (full);
		expected_pixels.push_back(overlay_pixel(px));
		pixels_sent++;
	endtask

	task automatic drain_all();
		push <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic program_geometry(int fw, int fh, int wide, int fine, int med);
		logic [CFG_IDX_W-1:0] idx[5];
		int                   value[5];
		idx = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_WIDE_BAND, REG_FINE_BAND,
			REG_MEDIUM_BAND};
		value = '{fw, fh, wide, fine, med};
		drain_all();
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= idx[i];
			cfg_data <= CFG_DATA_W'(value[i]);
			@(posedge clk);
			case (idx[i])
				REG_FRAME_WIDTH:  width_reg = COORD_BITS'(value[i]);
				REG_FRAME_HEIGHT: height_reg = COORD_BITS'(value[i]);
				REG_WIDE_BAND:    wide_reg = BAND_W'(value[i]);
				REG_FINE_BAND:    fine_reg = BAND_W'(value[i]);
				REG_MEDIUM_BAND:  med_reg = BAND_W'(value[i]);
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	// Tiny period so that every vertical band lands within a few pixels of the first line
	task automatic test_channel_extremes();
		program_geometry(8, 4, 1, 1, 1);
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1));
		send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b0));
		send_pixel(make_pixel(8'hAA, 8'h55, 8'hAA, 1'b0));
		send_pixel(make_pixel(8'h55, 8'hAA, 8'h55, 1'b0));
		send_pixel(make_pixel(8'hFF, 8'h00, 8'h80, 1'b0));
		send_pixel(make_pixel(8'h01, 8'hFE, 8'h7F, 1'b0));
	endtask

	// Zero geometry: every pixel closes its frame, zero fine and medium bands never apply
	task automatic test_zero_registers();
		program_geometry(0, 0, 0, 0, 0);
		send_pixel(random_pixel(1'b1));
		send_pixel(random_pixel(1'b0));
		send_pixel(random_pixel(1'b1));
		send_pixel(random_pixel(1'b0));
	endtask

	task automatic test_largest_registers();
		program_geometry(4095, 4095, 255, 255, 255);
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1));
		send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b0));
		send_pixel(random_pixel(1'b0));
		send_pixel(random_pixel(1'b0));
	endtask

	// Shrink the line under the running counters: the column is left beyond the frame
	task automatic test_midframe_change();
		program_geometry(12, 6, 2, 1, 3);
		send_pixel(random_pixel(1'b1));
		repeat (6) send_pixel(random_pixel(1'b0));
		program_geometry(4, 6, 1, 2, 1);
		repeat (3) send_pixel(random_pixel(1'b0));
	endtask

	task automatic test_random_frames();
		int fw, fh, wide, fine, med, count, goal;
		bit sof;
		goal = pixels_sent + RANDOM_ITEMS;
		while (pixels_sent < goal) begin
			case ($urandom_range(0, 9))
				0: begin
					// one or two pixels per line so that rows pass a wide period quickly
					fw = $urandom_range(0, 2);
					fh = $urandom_range(300, 4095);
					wide = $urandom_range(100, 255);
					fine = $urandom_range(0, 255);
					med = $urandom_range(0, 255);
					count = $urandom_range(200, 400);
				end
				1: begin
					wide = $urandom_range(40, 150);
					fw = 2 * wide + $urandom_range(0, 60);
					fh = $urandom_range(1, 3);
					fine = $urandom_range(0, 255);
					med = $urandom_range(0, 255);
					count = fw + 20;
				end
				2: begin
					fw = $urandom_range(0, 1) ? 4095 : $urandom_range(0, 1);
					fh = $urandom_range(0, 1) ? 4095 : $urandom_range(0, 1);
					wide = $urandom_range(0, 1) ? 255 : $urandom_range(0, 1);
					fine = $urandom_range(0, 1) ? 255 : $urandom_range(0, 1);
					med = $urandom_range(0, 1) ? 255 : $urandom_range(0, 1);
					count = 40;
				end
				default: begin
					fw = $urandom_range(1, 24);
					fh = $urandom_range(1, 16);
					wide = $urandom_range(0, 10);
					fine = $urandom_range(0, 12);
					med = $urandom_range(0, 12);
					count = $urandom_range(60, 160);
				end
			endcase
			feed_steady = $urandom_range(0, 3) == 0;
			drain_steady = $urandom_range(0, 3) == 0;
			program_geometry(fw, fh, wide, fine, med);
			for (int i = 0; i < count; i++) begin
				// mark most frame starts, now and then drop one or mark a pixel mid-frame
				if (col == 0 && row == 0)
					sof = $urandom_range(0, 19) != 0;
				else
					sof = $urandom_range(0, 39) == 0;
				send_pixel(random_pixel(sof));
			end
		end
		feed_steady = 1'b0;
		drain_steady = 1'b0;
	endtask

	initial begin : result_drain
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = idle_cycles(drain_steady);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	always @(posedge clk) begin : result_check
		pix_out_t want;
		if (arst_n && pop && !empty) begin
			if (expected_pixels.size() == 0) begin
				if (mismatches < 10)
					$display("beat %0d: pixel b=%0d g=%0d r=%0d eof=%b with none pending",
						pixels_popped, pix_out.blue_out, pix_out.green_out,
						pix_out.red_out, pix_out.end_of_frame);
				mismatches++;
			end else begin
				want = expected_pixels.pop_front();
				if (pix_out.blue_out !== want.blue_out ||
						pix_out.green_out !== want.green_out ||
						pix_out.red_out !== want.red_out ||
						pix_out.end_of_frame !== want.end_of_frame) begin
					if (mismatches < 10)
						$display("beat %0d: expected b=%0d g=%0d r=%0d eof=%b, got b=%0d g=%0d r=%0d eof=%b",
							pixels_popped, want.blue_out, want.green_out, want.red_out,
							want.end_of_frame, pix_out.blue_out, pix_out.green_out,
							pix_out.red_out, pix_out.end_of_frame);
					mismatches++;
				end
			end
			pixels_popped++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_channel_extremes();
		test_zero_registers();
		test_largest_registers();
		test_midframe_change();
		test_random_frames();
		drain_all();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/pbo_pkg.sv
hw/rtl/pbo_front.sv
hw/rtl/pbo_queue.sv
hw/rtl/pbo_back.sv
hw/rtl/plaid_band_overlay.sv
hw/rtl/pbo_checker.sv
verif/tb.sv
